// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the layout matrix RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/rlam_pkg.sv =====
// Package for the rectangle layout affine matrix block.
// Holds payload types, register indexes, CORDIC constants and helpers; no dependencies.
`default_nettype none
package rlam_pkg;

    // Angle resolution: a full turn is 2^ANGLE_BITS.
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int FRONT_STAGES = 2;
    localparam int BACK_STAGES  = 3;
    localparam int LATENCY      = FRONT_STAGES + CORDIC_STEPS + BACK_STAGES;

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_PW     = 3'd0;
    localparam logic [2:0] REG_PH     = 3'd1;
    localparam logic [2:0] REG_AMIN_X = 3'd2;
    localparam logic [2:0] REG_AMIN_Y = 3'd3;
    localparam logic [2:0] REG_AMAX_X = 3'd4;
    localparam logic [2:0] REG_AMAX_Y = 3'd5;
    localparam logic [2:0] REG_PIV_X  = 3'd6;
    localparam logic [2:0] REG_PIV_Y  = 3'd7;

    localparam logic [30:0] PW_RESET = 31'd125829120;
    localparam logic [30:0] PH_RESET = 31'd70778880;

    typedef struct packed {
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] width;
        logic signed [31:0] height;
        logic signed [15:0] scale_x_in;
        logic signed [15:0] scale_y_in;
        logic        [15:0] angle;
    } t_in;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m10;
        logic signed [31:0] m01;
        logic signed [31:0] m11;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
    } t_out;

    typedef struct packed {
        logic        [30:0] pw;
        logic        [30:0] ph;
        logic signed [15:0] amin_x;
        logic signed [15:0] amin_y;
        logic signed [15:0] amax_x;
        logic signed [15:0] amax_y;
        logic signed [15:0] piv_x;
        logic signed [15:0] piv_y;
    } t_cfg;

    // Rotation state handed from cell to cell.
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [33:0] z;
        logic               flip;
    } t_rot;

    // Data that rides along the chain untouched.
    typedef struct packed {
        logic signed [35:0] sw;
        logic signed [35:0] sh;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
    } t_pay;

    // Arctangent of 2^-i as a fraction of a half turn, Q31.
    function automatic logic signed [33:0] atan_step(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            default: v = $signed(34'd683565276 >> i);
        endcase
        return v;
    endfunction

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh00_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -40'sh00_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rect_layout_affine_matrix.sv =====
// Pipeline from start to o_strobe: 2 front stages, 30 CORDIC cells, 3 back stages.
// Throughput: one item per cycle; busy stays low, every cell takes a new item each cycle.
// Results are shown for one cycle with o_strobe; the receiver cannot stall.
// Reset (synchronous, active low) clears all valid flags and loads register defaults.
// Depends on rlam_pkg, rlam_front, rlam_cell, rlam_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rect_layout_affine_matrix (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire logic          start,
    output logic               busy,
    input  wire rlam_pkg::t_in i_item,
    output logic               o_strobe,
    output rlam_pkg::t_out     o_result
);
    import rlam_pkg::*;

    t_cfg       r_cfg;
    logic       n_wr;
    logic [2:0] n_idx;

    assign n_wr   = psel && penable && pwrite && pready;
    assign n_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign busy   = 1'b0;

    // Register file write on a completed transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pw     <= PW_RESET;
            r_cfg.ph     <= PH_RESET;
            r_cfg.amin_x <= '0;
            r_cfg.amin_y <= '0;
            r_cfg.amax_x <= '0;
            r_cfg.amax_y <= '0;
            r_cfg.piv_x  <= '0;
            r_cfg.piv_y  <= '0;
        end else if (n_wr) begin
            case (n_idx)
                REG_PW:     r_cfg.pw     <= pwdata[30:0];
                REG_PH:     r_cfg.ph     <= pwdata[30:0];
                REG_AMIN_X: r_cfg.amin_x <= pwdata[15:0];
                REG_AMIN_Y: r_cfg.amin_y <= pwdata[15:0];
                REG_AMAX_X: r_cfg.amax_x <= pwdata[15:0];
                REG_AMAX_Y: r_cfg.amax_y <= pwdata[15:0];
                REG_PIV_X:  r_cfg.piv_x  <= pwdata[15:0];
                REG_PIV_Y:  r_cfg.piv_y  <= pwdata[15:0];
                default:    r_cfg.pw     <= r_cfg.pw;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (n_idx)
            REG_PW:     prdata = {1'b0, r_cfg.pw};
            REG_PH:     prdata = {1'b0, r_cfg.ph};
            REG_AMIN_X: prdata = {16'd0, r_cfg.amin_x};
            REG_AMIN_Y: prdata = {16'd0, r_cfg.amin_y};
            REG_AMAX_X: prdata = {16'd0, r_cfg.amax_x};
            REG_AMAX_Y: prdata = {16'd0, r_cfg.amax_y};
            REG_PIV_X:  prdata = {16'd0, r_cfg.piv_x};
            REG_PIV_Y:  prdata = {16'd0, r_cfg.piv_y};
            default:    prdata = '0;
        endcase
    end

    logic v_chain [CORDIC_STEPS+1];
    t_rot rot_chain [CORDIC_STEPS+1];
    t_pay pay_chain [CORDIC_STEPS+1];

    rlam_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_valid (v_chain[0]),
        .o_rot   (rot_chain[0]),
        .o_pay   (pay_chain[0])
    );

    // Row of CORDIC cells, one micro-rotation each.
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        rlam_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (5'(g)),
            .i_valid (v_chain[g]),
            .i_rot   (rot_chain[g]),
            .i_pay   (pay_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_rot   (rot_chain[g+1]),
            .o_pay   (pay_chain[g+1])
        );
    end

    rlam_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v_chain[CORDIC_STEPS]),
        .i_rot    (rot_chain[CORDIC_STEPS]),
        .i_pay    (pay_chain[CORDIC_STEPS]),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Every result traces back to an earlier start.
    `ASSERT_IMP(a_latency, i_clk, i_rst_n, o_strobe, $past(start, LATENCY))
    // A width write lands in the register on the next cycle.
    `ASSERT_NXT(a_cfg_pw, i_clk, i_rst_n, n_wr && (n_idx == REG_PW), r_cfg.pw == $past(pwdata[30:0]))

endmodule
`default_nettype wire

// ===== rtl/rlam_front.sv =====
// Front end: size, anchor and pivot products, rounding, translation sums and CORDIC start values.
// Depends on rlam_pkg.
`default_nettype none
module rlam_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire rlam_pkg::t_in i_item,
    input  wire rlam_pkg::t_cfg i_cfg,
    output logic               o_valid,
    output rlam_pkg::t_rot     o_rot,
    output rlam_pkg::t_pay     o_pay
);
    import rlam_pkg::*;

    logic               r_v1, r_v2;
    logic signed [48:0] r_axp, r_ayp;
    logic signed [47:0] r_pvx, r_pvy, r_swp, r_shp;
    logic signed [31:0] r_ox, r_oy;
    t_rot               r_rot1, r_rot2;
    t_pay               r_pay2;

    logic signed [16:0] n_asum_x, n_asum_y;
    logic        [31:0] n_p, n_pz;
    logic               n_flip;
    t_rot               n_rot;

    // Angle folding into the right half-plane.
    always_comb begin
        n_asum_x = 17'(i_cfg.amin_x) + 17'(i_cfg.amax_x);
        n_asum_y = 17'(i_cfg.amin_y) + 17'(i_cfg.amax_y);
        n_p      = {16'd0, i_item.angle} << (32 - ANGLE_BITS);
        n_flip   = (n_p + 32'h4000_0000) >= 32'h8000_0000;
        n_pz     = n_flip ? (n_p ^ 32'h8000_0000) : n_p;
        n_rot.x    = CORDIC_GAIN;
        n_rot.y    = '0;
        n_rot.z    = 34'($signed(n_pz));
        n_rot.flip = n_flip;
    end

    // Stage one: products.
    always_ff @(posedge i_clk) begin
        r_axp  <= 49'(n_asum_x) * $signed({18'd0, i_cfg.pw});
        r_ayp  <= 49'(n_asum_y) * $signed({18'd0, i_cfg.ph});
        r_pvx  <= 48'(i_cfg.piv_x) * 48'(i_item.width);
        r_pvy  <= 48'(i_cfg.piv_y) * 48'(i_item.height);
        r_swp  <= 48'(i_item.width) * 48'(i_item.scale_x_in);
        r_shp  <= 48'(i_item.height) * 48'(i_item.scale_y_in);
        r_ox   <= i_item.offset_x;
        r_oy   <= i_item.offset_y;
        r_rot1 <= n_rot;
    end

    logic signed [48:0] n_axr, n_ayr;
    logic signed [47:0] n_pvxr, n_pvyr, n_swr, n_shr;
    logic signed [35:0] n_tx, n_ty;

    // Stage two: rounding and translation sums.
    always_comb begin
        n_axr  = r_axp + 49'sh4000;
        n_ayr  = r_ayp + 49'sh4000;
        n_pvxr = r_pvx + 48'sh2000;
        n_pvyr = r_pvy + 48'sh2000;
        n_swr  = r_swp + 48'sh800;
        n_shr  = r_shp + 48'sh800;
        n_tx = 36'($signed(n_axr[48:15])) + 36'(r_ox) - 36'($signed(n_pvxr[47:14]));
        n_ty = 36'($signed(n_ayr[48:15])) + 36'(r_oy) - 36'($signed(n_pvyr[47:14]));
    end

    always_ff @(posedge i_clk) begin
        r_pay2.sw <= n_swr[47:12];
        r_pay2.sh <= n_shr[47:12];
        r_pay2.tx <= sat32(40'(n_tx));
        r_pay2.ty <= sat32(40'(n_ty));
        r_rot2    <= r_rot1;
    end

    // Valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_rot   = r_rot2;
    assign o_pay   = r_pay2;

endmodule
`default_nettype wire

// ===== rtl/rlam_cell.sv =====
// One CORDIC rotation cell: one micro-rotation per item, payload carried along.
// Depends on rlam_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rlam_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [4:0]     i_step,
    input  wire logic           i_valid,
    input  wire rlam_pkg::t_rot i_rot,
    input  wire rlam_pkg::t_pay i_pay,
    output logic                o_valid,
    output rlam_pkg::t_rot      o_rot,
    output rlam_pkg::t_pay      o_pay
);
    import rlam_pkg::*;

    logic r_valid;
    t_rot r_rot;
    t_pay r_pay;
    t_rot n_rot;

    logic signed [32:0] n_dx, n_dy;
    logic signed [33:0] n_at;

    // Rotate toward zero residual angle.
    always_comb begin
        n_dx = i_rot.y >>> i_step;
        n_dy = i_rot.x >>> i_step;
        n_at = atan_step(i_step);
        n_rot.flip = i_rot.flip;
        if (!i_rot.z[33]) begin
            n_rot.x = i_rot.x - n_dx;
            n_rot.y = i_rot.y + n_dy;
            n_rot.z = i_rot.z - n_at;
        end else begin
            n_rot.x = i_rot.x + n_dx;
            n_rot.y = i_rot.y - n_dy;
            n_rot.z = i_rot.z + n_at;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
        r_pay <= i_pay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
    assign o_pay   = r_pay;

    // The residual angle and the x component stay well inside their registers.
    `ASSERT_IMP(a_z_range, i_clk, i_rst_n, r_valid, r_rot.z[33] == r_rot.z[32])
    `ASSERT_IMP(a_x_range, i_clk, i_rst_n, r_valid, r_rot.x[32] == r_rot.x[31])

endmodule
`default_nettype wire

// ===== rtl/rlam_back.sv =====
// Back end: sine and cosine rounding, matrix products, rounding and saturation.
// Depends on rlam_pkg.
`default_nettype none
module rlam_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire rlam_pkg::t_rot i_rot,
    input  wire rlam_pkg::t_pay i_pay,
    output logic                o_strobe,
    output rlam_pkg::t_out      o_result
);
    import rlam_pkg::*;

    logic               r_v1, r_v2, r_v3;
    logic signed [15:0] r_c, r_s, r_ns;
    t_pay               r_pay1;
    logic signed [51:0] r_p00, r_p10, r_p01, r_p11;
    logic signed [31:0] r_tx2, r_ty2;
    t_out               r_out;

    logic signed [32:0] n_xf, n_yf, n_xr, n_yr;
    logic signed [15:0] n_s;

    // Undo the half-turn fold and round to Q2.14.
    always_comb begin
        n_xf = i_rot.flip ? -i_rot.x : i_rot.x;
        n_yf = i_rot.flip ? -i_rot.y : i_rot.y;
        n_xr = n_xf + 33'sh8000;
        n_yr = n_yf + 33'sh8000;
        n_s  = n_yr[31:16];
    end

    always_ff @(posedge i_clk) begin
        r_c    <= n_xr[31:16];
        r_s    <= n_s;
        r_ns   <= -n_s;
        r_pay1 <= i_pay;
    end

    // Matrix products.
    always_ff @(posedge i_clk) begin
        r_p00 <= 52'(r_pay1.sw) * 52'(r_c);
        r_p10 <= 52'(r_pay1.sw) * 52'(r_s);
        r_p01 <= 52'(r_pay1.sh) * 52'(r_ns);
        r_p11 <= 52'(r_pay1.sh) * 52'(r_c);
        r_tx2 <= r_pay1.tx;
        r_ty2 <= r_pay1.ty;
    end

    logic signed [51:0] n_r00, n_r10, n_r01, n_r11;

    // Round and clamp into the result register.
    always_comb begin
        n_r00 = r_p00 + 52'sh2000;
        n_r10 = r_p10 + 52'sh2000;
        n_r01 = r_p01 + 52'sh2000;
        n_r11 = r_p11 + 52'sh2000;
    end

    always_ff @(posedge i_clk) begin
        r_out.m00     <= sat32(40'($signed(n_r00[51:14])));
        r_out.m10     <= sat32(40'($signed(n_r10[51:14])));
        r_out.m01     <= sat32(40'($signed(n_r01[51:14])));
        r_out.m11     <= sat32(40'($signed(n_r11[51:14])));
        r_out.trans_x <= r_tx2;
        r_out.trans_y <= r_ty2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_strobe = r_v3;
    assign o_result = r_out;

endmodule
`default_nettype wire
